[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent assertions used by the checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, ignored while reset is high.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also covers reset itself.
`define ASSERT_NXT_ALL(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/sfscm_pkg.sv]
// ---------------------------------------------------------------------------
// sfscm_pkg
// Types and codes shared by the sparse fuzzy subset column match block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfscm_pkg;

  localparam int unsigned ROW_INDEX_W = 16;
  localparam int unsigned GRADE_W     = 16;
  localparam int unsigned COLUMN_W    = 24;

  // Input operation codes.
  localparam logic [1:0] OP_QUERY_ENTRY = 2'd0;
  localparam logic [1:0] OP_CAND_ENTRY  = 2'd1;
  localparam logic [1:0] OP_EMPTY_COL   = 2'd2;
  localparam logic [1:0] OP_EMPTY_QUERY = 2'd3;

  // Command kinds passed from the front to the back.
  localparam logic [1:0] CMD_QUERY     = 2'd0;
  localparam logic [1:0] CMD_CAND      = 2'd1;
  localparam logic [1:0] CMD_EMPTY_COL = 2'd2;
  localparam logic [1:0] CMD_CLEAR     = 2'd3;

  typedef struct packed {
    logic [1:0]             operation;
    logic [ROW_INDEX_W-1:0] row_index;
    logic [GRADE_W-1:0]     grade;
    logic                   last;
  } sfscm_in_t;

  typedef struct packed {
    logic [COLUMN_W-1:0] column_index;
    logic                match;
    logic                query_overflow;
  } sfscm_out_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic                   start;
    logic                   last;
    logic [ROW_INDEX_W-1:0] row_index;
    logic [GRADE_W-1:0]     grade;
  } sfscm_cmd_t;

endpackage

`default_nettype wire

[rtl/sfscm_front.sv]
// ---------------------------------------------------------------------------
// sfscm_front
// Classifies incoming items, drops candidate and empty-column items during a
// query load and marks the query entry that starts a new load.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfscm_front
  import sfscm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire sfscm_in_t  item,
  input  wire logic       queue_full,
  output logic            cmd_push,
  output sfscm_cmd_t      cmd
);

  logic query_complete;
  logic query_complete_next;
  logic accept;
  logic keep;

  assign accept = push && !queue_full;

  always_comb begin
    keep = 1'b1;
    query_complete_next = query_complete;
    cmd.kind      = CMD_CLEAR;
    cmd.start     = query_complete;
    cmd.last      = item.last;
    cmd.row_index = item.row_index;
    cmd.grade     = item.grade;
    case (item.operation)
      OP_QUERY_ENTRY: begin
        cmd.kind = CMD_QUERY;
        query_complete_next = item.last;
      end
      OP_CAND_ENTRY: begin
        cmd.kind = CMD_CAND;
        keep = query_complete;
      end
      OP_EMPTY_COL: begin
        cmd.kind = CMD_EMPTY_COL;
        keep = query_complete;
      end
      OP_EMPTY_QUERY: begin
        cmd.kind = CMD_CLEAR;
        query_complete_next = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign cmd_push = accept && keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_complete <= 1'b1;
    end else if (accept) begin
      query_complete <= query_complete_next;
    end
  end

endmodule

`default_nettype wire

[rtl/sfscm_cmd_queue.sv]
// ---------------------------------------------------------------------------
// sfscm_cmd_queue
// Two-entry command queue between the front and the back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfscm_cmd_queue
  import sfscm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire sfscm_cmd_t  wr_data,
  output logic             full,
  output logic             rd_valid,
  output sfscm_cmd_t       rd_data,
  input  wire logic        rd_en
);

  sfscm_cmd_t slots [2];
  logic       wr_sel;
  logic       rd_sel;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = slots[rd_sel];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_sel] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_sel <= ~wr_sel;
      end
      if (do_rd) begin
        rd_sel <= ~rd_sel;
      end
      if (do_wr && !do_rd) begin
        count <= count + 2'd1;
      end else if (do_rd && !do_wr) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/sfscm_back.sv]
// ---------------------------------------------------------------------------
// sfscm_back
// Holds the query store and merges candidate entries against it, one command
// per cycle while its two-entry output result queue has room.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfscm_back
  import sfscm_pkg::*;
#(
  parameter int unsigned QUERY_DEPTH = 256,
  parameter int unsigned ROW_BITS    = 16,
  parameter int unsigned GRADE_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  input  wire sfscm_cmd_t  cmd,
  output logic             cmd_take,
  output logic             empty,
  input  wire logic        pop,
  output sfscm_out_t       result
);

  localparam int unsigned IDX_W   = (QUERY_DEPTH > 1) ? $clog2(QUERY_DEPTH) : 1;
  localparam int unsigned PTR_W   = $clog2(QUERY_DEPTH + 1);
  localparam int unsigned ROW_W   = (ROW_BITS < ROW_INDEX_W) ? ROW_BITS : ROW_INDEX_W;
  localparam int unsigned GRD_W   = (GRADE_BITS < GRADE_W) ? GRADE_BITS : GRADE_W;
  localparam int unsigned ENTRY_W = ROW_W + GRD_W;
  localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(QUERY_DEPTH);

  logic [ENTRY_W-1:0] mem [QUERY_DEPTH];
  logic [ENTRY_W-1:0] rd_entry;
  logic [ENTRY_W-1:0] wdata;
  logic [IDX_W-1:0]   waddr;
  logic [IDX_W-1:0]   raddr;
  logic               we;

  logic [PTR_W-1:0]    len, len_next;
  logic [PTR_W-1:0]    ptr, ptr_next;
  logic                failed, failed_next;
  logic [COLUMN_W-1:0] cnt, cnt_next;
  logic                ovf, ovf_next;
  logic [PTR_W-1:0]    base_len;
  logic [PTR_W-1:0]    cand_ptr;
  logic                cand_failed;
  logic [ROW_W-1:0]    cmd_row;
  logic [GRD_W-1:0]    cmd_grade;
  logic                emit;
  logic                emit_match;

  sfscm_out_t  res_slots [2];
  logic        res_wr_sel;
  logic        res_rd_sel;
  logic [1:0]  res_count;
  logic        res_pop;

  assign cmd_row   = cmd.row_index[ROW_W-1:0];
  assign cmd_grade = cmd.grade[GRD_W-1:0];
  assign cmd_take  = cmd_valid && (res_count != 2'd2);

  always_comb begin
    len_next    = len;
    ptr_next    = ptr;
    failed_next = failed;
    cnt_next    = cnt;
    ovf_next    = ovf;
    base_len    = cmd.start ? '0 : len;
    cand_ptr    = ptr;
    cand_failed = failed;
    we          = 1'b0;
    waddr       = base_len[IDX_W-1:0];
    wdata       = {cmd_row, cmd_grade};
    emit        = 1'b0;
    emit_match  = 1'b0;
    if (cmd_take) begin
      case (cmd.kind)
        CMD_CLEAR: begin
          len_next    = '0;
          ovf_next    = 1'b0;
          cnt_next    = '0;
          ptr_next    = '0;
          failed_next = 1'b0;
        end
        CMD_QUERY: begin
          if (cmd.start) begin
            ovf_next    = 1'b0;
            cnt_next    = '0;
            ptr_next    = '0;
            failed_next = 1'b0;
          end
          if (base_len < DEPTH_P) begin
            we       = 1'b1;
            len_next = base_len + PTR_W'(1);
          end else begin
            len_next = base_len;
            ovf_next = 1'b1;
          end
        end
        CMD_EMPTY_COL: begin
          emit       = 1'b1;
          emit_match = (len == '0);
        end
        CMD_CAND: begin
          if (!failed && (ptr < len) && (cmd_row == rd_entry[ENTRY_W-1:GRD_W])) begin
            if (cmd_grade >= rd_entry[GRD_W-1:0]) begin
              cand_ptr = ptr + PTR_W'(1);
            end else begin
              cand_failed = 1'b1;
            end
          end
          ptr_next    = cand_ptr;
          failed_next = cand_failed;
          emit        = cmd.last;
          emit_match  = !cand_failed && (cand_ptr == len);
        end
        default: begin
          emit = 1'b0;
        end
      endcase
      if (emit) begin
        cnt_next    = (cnt != '1) ? cnt + COLUMN_W'(1) : cnt;
        ptr_next    = '0;
        failed_next = 1'b0;
      end
    end
  end

  assign raddr = ptr_next[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rd_entry <= wdata;
    end else begin
      rd_entry <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len    <= '0;
      ptr    <= '0;
      failed <= 1'b0;
      cnt    <= '0;
      ovf    <= 1'b0;
    end else begin
      len    <= len_next;
      ptr    <= ptr_next;
      failed <= failed_next;
      cnt    <= cnt_next;
      ovf    <= ovf_next;
    end
  end

  assign res_pop = pop && (res_count != 2'd0);
  assign empty   = (res_count == 2'd0);
  assign result  = res_slots[res_rd_sel];

  always_ff @(posedge clk) begin
    if (emit) begin
      res_slots[res_wr_sel] <= '{column_index: cnt, match: emit_match, query_overflow: ovf};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr_sel <= 1'b0;
      res_rd_sel <= 1'b0;
      res_count  <= 2'd0;
    end else begin
      if (emit) begin
        res_wr_sel <= ~res_wr_sel;
      end
      if (res_pop) begin
        res_rd_sel <= ~res_rd_sel;
      end
      if (emit && !res_pop) begin
        res_count <= res_count + 2'd1;
      end else if (res_pop && !emit) begin
        res_count <= res_count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/sparse_fuzzy_subset_column_match.sv]
// ---------------------------------------------------------------------------
// sparse_fuzzy_subset_column_match
// Stores a sparse fuzzy query and reports, for each streamed column, whether
// the query is a fuzzy subset of it.
// ---------------------------------------------------------------------------
//  Channel   Handshake     Payload        Transfer when
//  input     push / full   item (in_t)    push && !full
//  result    empty / pop   result (out_t) pop && !empty
//
// One item is taken per cycle while full is low. The item closing a column is registered
// in the command queue, and its result then in the result queue, before it reaches the
// result ports when nothing is queued ahead. The rate is set by the single merge step
// in the back, which reads one query entry per cycle from a prefetched memory port.
// Reset is synchronous and leaves an empty, complete query; no clearing pass.
// A stalled result side fills the two-entry result and command queues, after
// which full rises.
`timescale 1ns / 1ps
`default_nettype none

module sparse_fuzzy_subset_column_match
  import sfscm_pkg::*;
#(
  parameter int unsigned QUERY_DEPTH = 256,
  parameter int unsigned ROW_BITS    = 16,
  parameter int unsigned GRADE_BITS  = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire sfscm_in_t  item,
  output logic            empty,
  input  wire logic       pop,
  output sfscm_out_t      result
);

  logic       cmd_push;
  sfscm_cmd_t front_cmd;
  logic       cmd_valid;
  sfscm_cmd_t back_cmd;
  logic       cmd_take;

  sfscm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .item       (item),
    .queue_full (full),
    .cmd_push   (cmd_push),
    .cmd        (front_cmd)
  );

  sfscm_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cmd_push),
    .wr_data  (front_cmd),
    .full     (full),
    .rd_valid (cmd_valid),
    .rd_data  (back_cmd),
    .rd_en    (cmd_take)
  );

  sfscm_back #(
    .QUERY_DEPTH (QUERY_DEPTH),
    .ROW_BITS    (ROW_BITS),
    .GRADE_BITS  (GRADE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (back_cmd),
    .cmd_take  (cmd_take),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

`default_nettype wire

[rtl/sfscm_checker.sv]
// ---------------------------------------------------------------------------
// sfscm_checker
// Port-level checks on the top level, attached by a bind statement.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sfscm_checker
  import sfscm_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       push,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire sfscm_out_t result
);

  // Reset leaves both queues empty.
  `ASSERT_NXT_ALL(a_reset_clear, clk, rst, empty && !full)

  // A waiting result holds until it is transferred.
  `ASSERT_NXT(a_result_hold, clk, rst, !empty && !pop, !empty && $stable(result))

  // The input side only fills up after an input transfer.
  `ASSERT_IMP(a_full_after_push, clk, rst, $rose(full), $past(push && !full))

endmodule

bind sparse_fuzzy_subset_column_match sfscm_checker u_checker (.*);

`default_nettype wire
